FILE: hw/rtl/mpm_pkg.sv
package mpm_pkg;

    localparam int NUM_PATTERNS  = 4;
    localparam int PATTERN_BYTES = 8;
    localparam int PAT_REGS      = 4;
    localparam int ACTIVE_LIM    = (NUM_PATTERNS < PAT_REGS) ? NUM_PATTERNS : PAT_REGS;
    localparam int WIN_W         = 8 * PATTERN_BYTES;
    localparam int LEN_W         = 4;
    localparam int POS_W         = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int PAT_W         = 64;
    localparam int COUNT_W       = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_A   = 3'd0,
        CFG_PATTERN_B   = 3'd1,
        CFG_PATTERN_C   = 3'd2,
        CFG_PATTERN_D   = 3'd3,
        CFG_LENGTHS     = 3'd4,
        CFG_COUNT       = 3'd5,
        CFG_MATCH_ANY   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [PAT_REGS-1:0][PAT_W-1:0] pattern;
        logic [PAT_REGS*LEN_W-1:0]      lengths;
        logic [COUNT_W-1:0]             count;
        logic                           match_any;
    } cfg_t;

    typedef struct packed {
        logic                verdict;
        logic [PAT_REGS-1:0] hits;
    } result_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/mpm_in_if.sv
interface mpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

FILE: hw/rtl/mpm_out_if.sv
interface mpm_out_if;
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [3:0] pattern_hits;

    modport source (output valid, verdict, pattern_hits, input ready);
    modport sink   (input valid, verdict, pattern_hits, output ready);
endinterface

FILE: hw/rtl/mpm_cfg_regs.sv
module mpm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mpm_pkg::cfg_t                   cfg
);
    import mpm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_A: cfg_reg.pattern[0] <= cfg_data[PAT_W-1:0];
                CFG_PATTERN_B: cfg_reg.pattern[1] <= cfg_data[PAT_W-1:0];
                CFG_PATTERN_C: cfg_reg.pattern[2] <= cfg_data[PAT_W-1:0];
                CFG_PATTERN_D: cfg_reg.pattern[3] <= cfg_data[PAT_W-1:0];
                CFG_LENGTHS:   cfg_reg.lengths    <= cfg_data[PAT_REGS*LEN_W-1:0];
                CFG_COUNT:     cfg_reg.count      <= cfg_data[COUNT_W-1:0];
                CFG_MATCH_ANY: cfg_reg.match_any  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/mpm_match.sv
module mpm_match (
    input  logic             clk,
    input  logic             rst_n,
    input  mpm_pkg::cfg_t    cfg,
    input  logic             step,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    output mpm_pkg::result_t res
);
    import mpm_pkg::*;

    logic [WIN_W-1:0]                 win_reg, win_next;
    logic [LEN_W-1:0]                 seen_reg, seen_next;
    logic [PAT_REGS-1:0]              found_reg, found_next;
    logic                             stopped_reg, stopped_next;
    logic                             take;
    logic [7:0]                       b_fold;
    logic [COUNT_W-1:0]               n_act;
    logic [PAT_REGS-1:0]              used, zero_len, hit_now, hits;
    logic [PAT_REGS-1:0][LEN_W-1:0]   len_raw, plen;
    logic [POS_W-1:0]                 pos;

    // active count and saturated lengths
    always_comb
    begin
        n_act = (cfg.count > COUNT_W'(ACTIVE_LIM)) ? COUNT_W'(ACTIVE_LIM) : cfg.count;
        for (int i = 0; i < PAT_REGS; i++)
        begin
            used[i]     = (COUNT_W'(i) < n_act);
            len_raw[i]  = cfg.lengths[i*LEN_W +: LEN_W];
            plen[i]     = (len_raw[i] > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES)
                                                                 : len_raw[i];
            zero_len[i] = (len_raw[i] == '0);
        end
    end

    always_comb
    begin
        b_fold       = fold_lower(text_byte);
        take         = !stopped_reg && (text_byte != 8'h00);
        stopped_next = stopped_reg || (text_byte == 8'h00);
        win_next     = take ? WIN_W'({win_reg, b_fold}) : win_reg;
        seen_next    = (take && seen_reg < LEN_W'(PATTERN_BYTES)) ? seen_reg + 1'b1 : seen_reg;
    end

    // newest byte in window byte 0; pattern char k meets window byte len-1-k
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < PAT_REGS; i++)
        begin
            hit_now[i] = used[i] && (seen_next >= plen[i]);
            for (int k = 0; k < PATTERN_BYTES; k++)
            begin
                if (LEN_W'(k) < plen[i])
                begin
                    pos = POS_W'(plen[i] - LEN_W'(k) - 1'b1);
                    if (win_next[8*pos +: 8] != fold_lower(cfg.pattern[i][8*k +: 8]))
                    begin
                        hit_now[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        found_next = found_reg | (take ? hit_now : '0);
        hits       = (found_next | zero_len) & used;
        res.hits   = hits;
        if (n_act == '0)
        begin
            res.verdict = 1'b0;
        end
        else if (cfg.match_any)
        begin
            res.verdict = (hits != '0);
        end
        else
        begin
            res.verdict = (hits == used);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            seen_reg    <= '0;
            found_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_text)
            begin
                win_reg     <= '0;
                seen_reg    <= '0;
                found_reg   <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                win_reg     <= win_next;
                seen_reg    <= seen_next;
                found_reg   <= found_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

FILE: hw/rtl/multi_pattern_any_all_matcher_top.sv
// Result path: the last text word is captured in the input register, then its
// result is written to the result register, which drives the result word.
// Throughput: one text word per cycle; the input register and the window compare
// of all patterns take a word each cycle; a last word waits while a result is pending.
// Reset: rst_n clears all config registers, the window, counts, hit flags
// and both handshake stages at once.
module multi_pattern_any_all_matcher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    mpm_in_if.sink                          text,
    mpm_out_if.source                       result
);
    import mpm_pkg::*;

    cfg_t       cfg;
    result_t    res;
    result_t    out_res_reg;
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_v_reg;
    logic       out_free;
    logic       advance;

    mpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpm_match u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .res         (res)
    );

    assign out_free   = !out_v_reg || result.ready;
    assign advance    = in_v_reg && (!in_last_reg || out_free);
    assign text.ready = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_v_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_v_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid        = out_v_reg;
    assign result.verdict      = out_res_reg.verdict;
    assign result.pattern_hits = out_res_reg.hits;

`ifndef ASSERT_OFF
    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> result.valid)
        else $error("last word advanced without a result word");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !advance |=> in_v_reg)
        else $error("held text word lost");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg && cfg.count == '0
        |=> !result.verdict && result.pattern_hits == '0)
        else $error("nonzero result with no patterns in use");
`endif

endmodule
